[hdl/bicubic_rgb_interpolator_macros.svh]
// assertion helpers shared by the checking code of the interpolator
`ifndef BICUBIC_RGB_INTERPOLATOR_MACROS_SVH
`define BICUBIC_RGB_INTERPOLATOR_MACROS_SVH

// same-cycle implication, held off while in reset
`define BRI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bicubic interpolator check failed");

// next-cycle implication, held off while in reset
`define BRI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bicubic interpolator check failed");

`endif

[hdl/bri_pkg.sv]
package bri_pkg;

  localparam int NUM_TAPS  = 4;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int FRAC_IN_W = 8;
  localparam int CH_MAX    = 255;

  // kernel and lane pipelines are both four registers deep
  localparam int CNT_W = 2;
  localparam logic [CNT_W-1:0] LAT_LAST = CNT_W'(3);

  typedef struct packed {
    logic acc_en;
    logic acc_clr;
  } bri_lane_ctrl_t;

endpackage

[hdl/bri_kernel.sv]
module bri_kernel #(
  parameter int FRAC_BITS   = 8,
  parameter int WEIGHT_BITS = 14
) (
  input  logic                          clk,
  input  logic [FRAC_BITS+1:0]          tap_dist,
  output logic signed [WEIGHT_BITS+1:0] weight
);

  localparam int TW  = FRAC_BITS + 2;
  localparam int WW  = WEIGHT_BITS + 2;
  localparam int SH  = 3 * FRAC_BITS - WEIGHT_BITS;
  localparam int LSH = (SH < 0) ? -SH : 0;
  localparam int NW  = 3 * FRAC_BITS + 7 + LSH;

  localparam logic [TW-1:0]        D_T = TW'(1) << FRAC_BITS;
  localparam logic signed [NW-1:0] D3  = NW'(1) <<< (3 * FRAC_BITS);

  logic [TW-1:0]          d1_r, d2_r;
  logic [2*TW-1:0]        sq1_r, sq2_r;
  logic [3*TW-1:0]        cube2_r;
  logic signed [NW-1:0]   num_nxt, num_r;
  logic signed [NW-1:0]   d_s, sq_s, cube_s;
  logic signed [NW-1:0]   rnd;
  logic signed [WW-1:0]   weight_r;

  // square, then cube
  always_ff @(posedge clk) begin
    d1_r    <= tap_dist;
    sq1_r   <= tap_dist * tap_dist;
    d2_r    <= d1_r;
    sq2_r   <= sq1_r;
    cube2_r <= sq1_r * d1_r;
  end

  // polynomial of the inner or outer piece, scaled by 2^(3*frac)
  always_comb begin
    d_s    = $signed(NW'(d2_r));
    sq_s   = $signed(NW'(sq2_r));
    cube_s = $signed(NW'(cube2_r));
    if (d2_r <= D_T) begin
      num_nxt = D3 - (sq_s <<< (FRAC_BITS + 1)) + cube_s;
    end else if (d2_r < (D_T << 1)) begin
      num_nxt = (D3 <<< 2) - (d_s <<< (2 * FRAC_BITS + 3))
              + (sq_s <<< (FRAC_BITS + 2)) + (sq_s <<< FRAC_BITS) - cube_s;
    end else begin
      num_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
  end

  generate
    if (SH > 0) begin : g_round
      localparam logic signed [NW-1:0] HALF = NW'(1) <<< (SH - 1);
      assign rnd = (num_r + HALF) >>> SH;
    end else begin : g_scale
      assign rnd = num_r <<< LSH;
    end
  endgenerate

  always_ff @(posedge clk) begin
    weight_r <= $signed(rnd[WW-1:0]);
  end

  assign weight = weight_r;

endmodule

[hdl/bri_lane.sv]
module bri_lane #(
  parameter int WEIGHT_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bri_pkg::bri_lane_ctrl_t        ctrl,
  input  logic [bri_pkg::CH_W-1:0]       pix   [bri_pkg::NUM_TAPS],
  input  logic signed [WEIGHT_BITS+1:0]  w_col [bri_pkg::NUM_TAPS],
  input  logic signed [WEIGHT_BITS+1:0]  w_row,
  output logic signed [WEIGHT_BITS+12:0] acc
);

  import bri_pkg::*;

  localparam int WW    = WEIGHT_BITS + 2;
  localparam int PRW   = WW + CH_W + 1;
  localparam int RW    = WEIGHT_BITS + 12;
  localparam int PW    = WW + RW;
  localparam int ACC_W = WEIGHT_BITS + 13;

  logic signed [PRW-1:0]   prod_r [NUM_TAPS];
  logic signed [RW-1:0]    rowsum_nxt, rowsum_r;
  logic signed [PW-1:0]    wprod_r;
  logic signed [PW-1:0]    wshift;
  logic signed [ACC_W-1:0] acc_nxt, acc_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_TAPS; j++) begin
      prod_r[j] <= w_col[j] * $signed({1'b0, pix[j]});
    end
  end

  always_comb begin
    rowsum_nxt = '0;
    for (int j = 0; j < NUM_TAPS; j++) begin
      rowsum_nxt = rowsum_nxt + RW'(prod_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    rowsum_r <= rowsum_nxt;
    wprod_r  <= w_row * rowsum_r;
  end

  // row contribution floored back to the weight scale
  assign wshift = wprod_r >>> WEIGHT_BITS;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctrl.acc_en) begin
      acc_nxt = acc_r + $signed(wshift[ACC_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

[hdl/bicubic_rgb_interpolator.sv]
// Bicubic RGB interpolator, cubic kernel with a = -1. A 4x4 window enters as
// four beats, one row per beat, four 24-bit pixels each; frac_u and frac_v are
// taken from the first row of a window and ignored on the other three. After
// the fourth row one beat carries the three channels, floored and clamped to
// 0..255. The first row of a window passes through the kernel pipeline that
// turns the fractions into eight tap weights, then through the channel lane
// pipeline (products, row sum, row weight, accumulate). Later rows pass only
// through the lane pipeline, and after the last row the result waits until
// the result register is free; a result left waiting on out_stall only
// holds the last row's handoff, the next window's first row is already taken.
`include "bicubic_rgb_interpolator_macros.svh"

module bicubic_rgb_interpolator #(
  parameter int FRAC_BITS   = 8,
  parameter int WEIGHT_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bri_pkg::PIX_W-1:0]     in_pixel_c0,
  input  logic [bri_pkg::PIX_W-1:0]     in_pixel_c1,
  input  logic [bri_pkg::PIX_W-1:0]     in_pixel_c2,
  input  logic [bri_pkg::PIX_W-1:0]     in_pixel_c3,
  input  logic [bri_pkg::FRAC_IN_W-1:0] in_frac_u,
  input  logic [bri_pkg::FRAC_IN_W-1:0] in_frac_v,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bri_pkg::CH_W-1:0]      out_chan0,
  output logic [bri_pkg::CH_W-1:0]      out_chan1,
  output logic [bri_pkg::CH_W-1:0]      out_chan2
);

  import bri_pkg::*;

  localparam int TW    = FRAC_BITS + 2;
  localparam int WW    = WEIGHT_BITS + 2;
  localparam int ACC_W = WEIGHT_BITS + 13;

  // one tap spacing in distance units
  localparam logic [TW-1:0] D_T = TW'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_KERN = 4'b0010,
    ST_MAC  = 4'b0100,
    ST_DONE = 4'b1000
  } bri_state_t;

  bri_state_t state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           row_idx_r, row_idx_nxt;
  logic [FRAC_IN_W-1:0] lat_u_r, lat_u_nxt;
  logic [FRAC_IN_W-1:0] lat_v_r, lat_v_nxt;
  logic [PIX_W-1:0]     px_r   [NUM_TAPS];
  logic [PIX_W-1:0]     px_nxt [NUM_TAPS];
  logic [PIX_W-1:0]     in_px  [NUM_TAPS];

  logic                 out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]      out_chan_r   [NUM_CH];
  logic [CH_W-1:0]      out_chan_nxt [NUM_CH];
  logic [CH_W-1:0]      sat          [NUM_CH];
  logic                 out_free;
  logic                 in_beat;

  bri_lane_ctrl_t       lane_ctrl;

  logic [FRAC_BITS-1:0] fu, fv;
  logic [TW-1:0]        t_col [NUM_TAPS];
  logic [TW-1:0]        t_row [NUM_TAPS];
  logic signed [WW-1:0] w_col [NUM_TAPS];
  logic signed [WW-1:0] w_row [NUM_TAPS];
  logic signed [WW-1:0] w_cur;
  logic signed [ACC_W-1:0] acc [NUM_CH];

  assign in_px[0] = in_pixel_c0;
  assign in_px[1] = in_pixel_c1;
  assign in_px[2] = in_pixel_c2;
  assign in_px[3] = in_pixel_c3;

  assign in_stall = (state_r != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------
  // tap distances: fractions wider than FRAC_BITS keep only the low bits
  // ---------------------------------------------------------------------
  assign fu = FRAC_BITS'(lat_u_r);
  assign fv = FRAC_BITS'(lat_v_r);

  always_comb begin
    t_col[0] = D_T + TW'(fv);
    t_col[1] = TW'(fv);
    t_col[2] = D_T - TW'(fv);
    t_col[3] = (D_T << 1) - TW'(fv);
    t_row[0] = D_T + TW'(fu);
    t_row[1] = TW'(fu);
    t_row[2] = D_T - TW'(fu);
    t_row[3] = (D_T << 1) - TW'(fu);
  end

  // kernel cells run freely off the latched fractions; the weights settle after
  // the kernel registers and then hold for the whole window
  generate
    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_kern
      bri_kernel #(
        .FRAC_BITS   (FRAC_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
      ) u_kern_col (
        .clk      (clk),
        .tap_dist (t_col[k]),
        .weight   (w_col[k])
      );
      bri_kernel #(
        .FRAC_BITS   (FRAC_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
      ) u_kern_row (
        .clk      (clk),
        .tap_dist (t_row[k]),
        .weight   (w_row[k])
      );
    end
  endgenerate

  // weight of the row now in the lanes
  assign w_cur = w_row[row_idx_r];

  // ---------------------------------------------------------------------
  // one lane per color channel
  // ---------------------------------------------------------------------
  generate
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
      logic [CH_W-1:0] lane_pix [NUM_TAPS];

      for (genvar j = 0; j < NUM_TAPS; j++) begin : g_pix
        assign lane_pix[j] = px_r[j][c*CH_W +: CH_W];
      end

      bri_lane #(
        .WEIGHT_BITS (WEIGHT_BITS)
      ) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .pix   (lane_pix),
        .w_col (w_col),
        .w_row (w_cur),
        .acc   (acc[c])
      );
    end
  endgenerate

  // merge: floor away the weight scale and clamp each channel
  always_comb begin
    logic signed [ACC_W-1:0] v;
    for (int c = 0; c < NUM_CH; c++) begin
      v = acc[c] >>> WEIGHT_BITS;
      if (v < 0) begin
        sat[c] = '0;
      end else if (v > $signed(ACC_W'(CH_MAX))) begin
        sat[c] = CH_W'(CH_MAX);
      end else begin
        sat[c] = v[CH_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_idx_nxt   = row_idx_r;
    lat_u_nxt     = lat_u_r;
    lat_v_nxt     = lat_v_r;
    px_nxt        = px_r;
    out_chan_nxt  = out_chan_r;
    out_valid_nxt = out_valid_r && out_stall;
    lane_ctrl     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          px_nxt  = in_px;
          cnt_nxt = '0;
          if (row_idx_r == 2'd0) begin
            lat_u_nxt = in_frac_u;
            lat_v_nxt = in_frac_v;
            state_nxt = ST_KERN;
          end else begin
            state_nxt = ST_MAC;
          end
        end
      end
      ST_KERN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAT_LAST) begin
          // row contribution reaches the accumulators
          cnt_nxt          = '0;
          lane_ctrl.acc_en = 1'b1;
          if (row_idx_r == 2'd3) begin
            state_nxt = ST_DONE;
          end else begin
            row_idx_nxt = row_idx_r + 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_chan_nxt      = sat;
          out_valid_nxt     = 1'b1;
          lane_ctrl.acc_clr = 1'b1;
          row_idx_nxt       = 2'd0;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      row_idx_r   <= '0;
      lat_u_r     <= '0;
      lat_v_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_idx_r   <= row_idx_nxt;
      lat_u_r     <= lat_u_nxt;
      lat_v_r     <= lat_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // row and result payload
  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    out_chan_r <= out_chan_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_chan0 = out_chan_r[0];
  assign out_chan1 = out_chan_r[1];
  assign out_chan2 = out_chan_r[2];

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // a first row always waits for fresh weights
  `BRI_ASSERT_NEXT(a_row0_kern, in_beat && row_idx_r == 2'd0, state_r == ST_KERN)
  // only the last row of a window leads to the result handoff
  `BRI_ASSERT_NOW(a_done_row3, state_r == ST_DONE, row_idx_r == 2'd3)
  // a handoff leaves a loaded result and a fresh window
  `BRI_ASSERT_NEXT(a_handoff, state_r == ST_DONE && out_free,
                   out_valid_r && state_r == ST_IDLE && row_idx_r == 2'd0)
  // fractions hold while a row is in flight
  `BRI_ASSERT_NEXT(a_frac_hold, state_r != ST_IDLE, $stable(lat_u_r) && $stable(lat_v_r))

endmodule
